FILE: src/ddo_pkg.sv
// Shared types, widths and constants of the differential drive odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int CRD_W  = 56;
  localparam int CRD_ZW = 34;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  localparam logic [2:0] REG_ANGLE_L  = 3'd0;
  localparam logic [2:0] REG_ANGLE_R  = 3'd1;
  localparam logic [2:0] REG_LENGTH_L = 3'd2;
  localparam logic [2:0] REG_LENGTH_R = 3'd3;
  localparam logic [2:0] REG_START_X  = 3'd4;
  localparam logic [2:0] REG_START_Y  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SPEED,
    ST_ROT,
    ST_MOVE,
    ST_AIM,
    ST_VEC,
    ST_MAG,
    ST_OUT
  } ddo_state_t;

  // Arctangent of 2^-i in 32-bit binary angle units.
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: src/differential_drive_odometry_core.sv
// Top level of the differential drive odometry block with its sequencer.
//
// Usage: configuration is written over cfg_valid/cfg_ready (always ready) with
// cfg_index selecting one of six registers; writes to indexes six and seven are
// dropped. Each input item carries wheel ticks, a target point and a restart
// flag; each item yields exactly one result item with the updated position,
// heading, speed, target distance and bearing.
// The four multiply pairs run through two bit-serial multipliers and the
// sine/cosine and distance/bearing passes use one iterative CORDIC unit; the
// vectoring pass is skipped when the target lies on the new position. One
// item is processed at a time; in_ready is high only while the sequencer is
// idle, so no new item is accepted while one is in progress. A finished
// result sits in the output register, so the next item is accepted while it
// waits; if the receiver stalls longer than one item's processing time, the
// sequencer holds at its last step until the output register is free. Reset
// clears configuration, position, heading and the travelled distance, and
// empties the output register.
`timescale 1ns / 1ps
module differential_drive_odometry_core import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_ticks_left,
  input  logic [15:0] in_ticks_right,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [15:0] out_heading,
  output logic [31:0] out_speed,
  output logic [31:0] out_target_distance,
  output logic [15:0] out_target_bearing
);

  ddo_state_t state_r, state_nxt;

  logic [23:0] acl_r, acr_r, lcl_r, lcr_r;
  logic [31:0] start_x_r, start_y_r;
  logic [31:0] pos_x_r, pos_y_r;
  logic [15:0] heading_r;
  logic [47:0] dist_r;
  logic [31:0] speed_r;
  logic        flip_r;
  logic [15:0] tl_r, tr_r;
  logic [31:0] tx_r, ty_r;
  logic [31:0] mag_r;
  logic [15:0] ang_r;
  logic        out_valid_r;
  logic [31:0] o_px_r, o_py_r, o_sp_r, o_mag_r;
  logic [15:0] o_hd_r, o_ang_r;

  logic              mul_start;
  logic [5:0]        mul_nbits;
  logic [MUL_AW-1:0] mul_a0, mul_a1;
  logic [MUL_BW-1:0] mul_b0, mul_b1;
  logic              mul_done0, mul_done1;
  logic [MUL_PW-1:0] prod0, prod1;

  logic              cor_start;
  logic              cor_rot;
  logic [CRD_W-1:0]  cor_x0, cor_y0, cor_x, cor_y;
  logic [CRD_ZW-1:0] cor_z0, cor_z;
  logic              cor_done;

  logic              out_free;
  logic [31:0]       hsum;
  logic [41:0]       ssum;
  logic [31:0]       speed_c;
  logic [31:0]       hz, hzf;
  logic              flip_c;
  logic [CRD_W-1:0]  sin_c, cos_c;
  logic [61:0]       dsx, dsy;
  logic [32:0]       dx, dy;
  logic              at_target;
  logic [CRD_W-1:0]  vx0, vy0;
  logic [CRD_W-1:0]  ux;
  logic [63:0]       tmag;
  logic [63:0]       tround;
  logic [31:0]       bsum;

  assign out_free = !out_valid_r || out_ready;

  assign hsum    = prod0[31:0] - prod1[31:0] + 32'h0000_8000;
  assign ssum    = prod0[41:0] + prod1[41:0] + 42'h1_0000;
  assign speed_c = {{7{ssum[41]}}, ssum[41:17]};

  // Fold the heading into the right half plane; the result is negated after.
  assign hz     = {heading_r, 16'h0000};
  assign flip_c = hz[31] ^ hz[30];
  assign hzf    = flip_c ? (hz ^ 32'h8000_0000) : hz;

  assign sin_c = flip_r ? -cor_y : cor_y;
  assign cos_c = flip_r ? -cor_x : cor_x;

  assign dsx = prod0[61:0] + 62'h2000_0000;
  assign dsy = prod1[61:0] + 62'h2000_0000;

  assign dx        = {tx_r[31], tx_r} - {pos_x_r[31], pos_x_r};
  assign dy        = {ty_r[31], ty_r} - {pos_y_r[31], pos_y_r};
  assign at_target = (dx == '0) && (dy == '0);
  assign vx0       = {{3{dy[32]}}, dy, 20'h00000};
  assign vy0       = {{3{dx[32]}}, dx, 20'h00000};

  assign ux     = cor_x[CRD_W-1] ? '0 : cor_x;
  assign tmag   = prod0[63:0] + {27'h0, prod1[63:27]};
  assign tround = tmag + 64'h40_0000;
  assign bsum   = cor_z[31:0] + 32'h0000_8000;

  ddo_smul u_mul0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a0),
    .b     (mul_b0),
    .nbits (mul_nbits),
    .done  (mul_done0),
    .prod  (prod0)
  );

  ddo_smul u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a1),
    .b     (mul_b1),
    .nbits (mul_nbits),
    .done  (mul_done1),
    .prod  (prod1)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cor_start),
    .rot_mode (cor_rot),
    .x0       (cor_x0),
    .y0       (cor_y0),
    .z0       (cor_z0),
    .done     (cor_done),
    .x        (cor_x),
    .y        (cor_y),
    .z        (cor_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_nbits = 6'd16;
    mul_a0    = '0;
    mul_b0    = '0;
    mul_a1    = '0;
    mul_b1    = '0;
    cor_start = 1'b0;
    cor_rot   = 1'b1;
    cor_x0    = '0;
    cor_y0    = '0;
    cor_z0    = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mul_a0   = {10'h000, acl_r};
        mul_b0   = {{17{in_ticks_left[15]}}, in_ticks_left};
        mul_a1   = {10'h000, acr_r};
        mul_b1   = {{17{in_ticks_right[15]}}, in_ticks_right};
        if (in_valid) begin
          mul_start = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        mul_a0 = {10'h000, lcl_r};
        mul_b0 = {{17{tl_r[15]}}, tl_r};
        mul_a1 = {10'h000, lcr_r};
        mul_b1 = {{17{tr_r[15]}}, tr_r};
        if (mul_done0) begin
          mul_start = 1'b1;
          state_nxt = ST_SPEED;
        end
      end
      ST_SPEED: begin
        cor_x0 = {24'h0, GAIN_Q30};
        cor_z0 = {{2{hzf[31]}}, hzf};
        if (mul_done0) begin
          cor_start = 1'b1;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        mul_nbits = 6'd32;
        mul_a0    = sin_c[MUL_AW-1:0];
        mul_b0    = {speed_r[31], speed_r};
        mul_a1    = cos_c[MUL_AW-1:0];
        mul_b1    = {speed_r[31], speed_r};
        if (cor_done) begin
          mul_start = 1'b1;
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (mul_done0) begin
          state_nxt = ST_AIM;
        end
      end
      ST_AIM: begin
        cor_rot = 1'b0;
        cor_x0  = vx0[CRD_W-1] ? -vx0 : vx0;
        cor_y0  = vx0[CRD_W-1] ? -vy0 : vy0;
        cor_z0  = vx0[CRD_W-1] ? 34'h0_8000_0000 : '0;
        if (at_target) begin
          state_nxt = ST_OUT;
        end else begin
          cor_start = 1'b1;
          state_nxt = ST_VEC;
        end
      end
      ST_VEC: begin
        mul_nbits = 6'd30;
        mul_a0    = {2'b00, GAIN_Q30};
        mul_b0    = {4'h0, ux[CRD_W-1:27]};
        mul_a1    = {2'b00, GAIN_Q30};
        mul_b1    = {6'h00, ux[26:0]};
        if (cor_done) begin
          mul_start = 1'b1;
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        if (mul_done0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acl_r       <= '0;
      acr_r       <= '0;
      lcl_r       <= '0;
      lcr_r       <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ANGLE_L:  acl_r     <= cfg_data[23:0];
          REG_ANGLE_R:  acr_r     <= cfg_data[23:0];
          REG_LENGTH_L: lcl_r     <= cfg_data[23:0];
          REG_LENGTH_R: lcr_r     <= cfg_data[23:0];
          REG_START_X:  start_x_r <= cfg_data;
          REG_START_Y:  start_y_r <= cfg_data;
          default: ;
        endcase
      end
      // In the result step the output register is reloaded below instead.
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            tl_r <= in_ticks_left;
            tr_r <= in_ticks_right;
            tx_r <= in_target_x;
            ty_r <= in_target_y;
            if (in_restart) begin
              pos_x_r   <= start_x_r;
              pos_y_r   <= start_y_r;
              heading_r <= '0;
              dist_r    <= '0;
            end
          end
        end
        ST_HEAD: begin
          if (mul_done0) begin
            heading_r <= heading_r + hsum[31:16];
          end
        end
        ST_SPEED: begin
          if (mul_done0) begin
            speed_r <= speed_c;
            dist_r  <= dist_r + {{16{speed_c[31]}}, speed_c};
            flip_r  <= flip_c;
          end
        end
        ST_MOVE: begin
          if (mul_done0) begin
            pos_x_r <= pos_x_r - dsx[61:30];
            pos_y_r <= pos_y_r + dsy[61:30];
          end
        end
        ST_AIM: begin
          mag_r <= '0;
          ang_r <= '0;
        end
        ST_MAG: begin
          if (mul_done0) begin
            mag_r <= (tround[63:55] != '0) ? 32'hFFFF_FFFF : tround[54:23];
            ang_r <= bsum[31:16];
          end
        end
        ST_OUT: begin
          if (out_free) begin
            o_px_r      <= pos_x_r;
            o_py_r      <= pos_y_r;
            o_hd_r      <= heading_r;
            o_sp_r      <= speed_r;
            o_mag_r     <= mag_r;
            o_ang_r     <= ang_r;
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_pos_x           = o_px_r;
  assign out_pos_y           = o_py_r;
  assign out_heading         = o_hd_r;
  assign out_speed           = o_sp_r;
  assign out_target_distance = o_mag_r;
  assign out_target_bearing  = o_ang_r;

  asrt_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done0 |-> (state_r == ST_HEAD || state_r == ST_SPEED ||
                   state_r == ST_MOVE || state_r == ST_MAG))
    else $error("multiplier finished outside a multiply step");

  asrt_mul_pair: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done0 == mul_done1) else $error("multiplier pair out of step");

  asrt_cor_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == ST_ROT || state_r == ST_VEC))
    else $error("CORDIC finished outside a CORDIC step");

  asrt_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !out_free) |=> state_r == ST_OUT)
    else $error("result step left while output register was full");
endmodule

FILE: src/ddo_smul.sv
// Bit-serial signed shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ddo_smul import ddo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  input  logic [5:0]        nbits,
  output logic              done,
  output logic [MUL_PW-1:0] prod
);

  logic [MUL_PW-1:0] m_r;
  logic [MUL_PW-1:0] acc_r;
  logic [MUL_BW-1:0] b_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              last;

  // The top bit of the multiplier carries negative weight.
  assign last = (cnt_r == 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        m_r    <= {{(MUL_PW-MUL_AW){a[MUL_AW-1]}}, a};
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= last ? acc_r - m_r : acc_r + m_r;
        end
        m_r   <= {m_r[MUL_PW-2:0], 1'b0};
        b_r   <= {1'b0, b_r[MUL_BW-1:1]};
        cnt_r <= cnt_r - 6'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  asrt_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("multiplier restarted while busy");
endmodule

FILE: src/ddo_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
`timescale 1ns / 1ps
module ddo_cordic import ddo_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              rot_mode,
  input  logic [CRD_W-1:0]  x0,
  input  logic [CRD_W-1:0]  y0,
  input  logic [CRD_ZW-1:0] z0,
  output logic              done,
  output logic [CRD_W-1:0]  x,
  output logic [CRD_W-1:0]  y,
  output logic [CRD_ZW-1:0] z
);

  logic [CRD_W-1:0]  x_r;
  logic [CRD_W-1:0]  y_r;
  logic [CRD_ZW-1:0] z_r;
  logic [4:0]        cnt_r;
  logic              rot_r;
  logic              busy_r;
  logic              done_r;
  logic [CRD_W-1:0]  xs;
  logic [CRD_W-1:0]  ys;
  logic [CRD_ZW-1:0] at;
  logic              ccw;

  assign xs = CRD_W'($signed(x_r) >>> cnt_r);
  assign ys = CRD_W'($signed(y_r) >>> cnt_r);
  assign at = {2'b00, atan_tab(cnt_r)};
  // Rotation drives z toward zero, vectoring drives y toward zero.
  assign ccw = rot_r ? !z_r[CRD_ZW-1] : !(!y_r[CRD_W-1] && (y_r != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
        rot_r  <= rot_mode;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ccw) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

  asrt_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < 5'(STEPS)) else $error("CORDIC step count out of range");
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the differential drive odometry core.
`timescale 1ns / 1ps
module tb_top import ddo_pkg::*; ;

  localparam int STEPS      = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 200;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [15:0] tl;
    logic [15:0] tr;
    logic [31:0] tx;
    logic [31:0] ty;
    logic        rs;
  } odo_item_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] hd;
    logic [31:0] sp;
    logic [31:0] rng;
    logic [15:0] brg;
  } odo_fix_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [15:0] in_ticks_left, in_ticks_right;
  logic [31:0] in_target_x, in_target_y;
  logic in_restart;
  logic out_valid, out_ready;
  logic [31:0] out_pos_x, out_pos_y, out_speed, out_target_distance;
  logic [15:0] out_heading, out_target_bearing;

  differential_drive_odometry_core #(.CORDIC_STEPS(STEPS)) DUT (.*);

  // Shadow configuration and odometry state.
  logic [23:0] k_ang_l, k_ang_r, k_len_l, k_len_r;
  logic [31:0] home_x, home_y;
  logic [31:0] at_x, at_y;
  logic [15:0] head;
  logic [47:0] travelled;

  odo_item_t pending_items[$];
  odo_fix_t  expected_fixes[$];
  odo_item_t driven_item;
  int send_idle_pct, recv_stall_pct;
  int errors;
  int quiet_cycles = 0;

  logic [31:0] arctan[24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  task automatic heading_sincos(input logic [15:0] h, output longint s, output longint c);
    logic [31:0] z;
    logic flip;
    longint x, y, zs, xs, ys;
    z = {h, 16'h0000};
    flip = z[31] ^ z[30];
    if (flip) z ^= 32'h80000000;
    zs = longint'(signed'(z));
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (zs >= 0) begin
        x -= ys; y += xs; zs -= longint'(arctan[i]);
      end else begin
        x += ys; y -= xs; zs += longint'(arctan[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Vectoring pass on (dy, dx): range and bearing to the target.
  task automatic range_bearing(input longint a, input longint b,
                               output logic [31:0] mag, output logic [15:0] ang);
    longint x, y, xs, ys;
    logic [31:0] z;
    logic [63:0] ux, hi, lo, t;
    z = '0;
    if (a == 0 && b == 0) begin
      mag = '0;
      ang = '0;
    end else begin
      x = a * (64'sd1 <<< 20);
      y = b * (64'sd1 <<< 20);
      if (x < 0) begin
        x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += arctan[i];
        end else begin
          x -= ys; y += xs; z -= arctan[i];
        end
      end
      ux = (x < 0) ? 64'd0 : 64'(x);
      hi = ux >> 27;
      lo = ux & ((64'd1 << 27) - 1);
      t = hi * 64'(GAIN_Q30) + ((lo * 64'(GAIN_Q30)) >> 27);
      t = (t + (64'd1 << 22)) >> 23;
      mag = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
      z = z + 32'h8000;
      ang = z[31:16];
    end
  endtask

  task automatic advance_odometry(input odo_item_t it, output odo_fix_t f);
    longint tl, tr, diff, inc, sum, spd, s, c, dxp, dyp;
    logic [31:0] mag;
    logic [15:0] ang;
    tl = longint'(signed'(it.tl));
    tr = longint'(signed'(it.tr));
    if (it.rs) begin
      at_x = home_x; at_y = home_y; head = '0; travelled = '0;
    end
    diff = longint'(k_ang_l) * tl - longint'(k_ang_r) * tr;
    inc = (diff + 64'sd32768) >>> 16;
    head = head + inc[15:0];
    sum = longint'(k_len_l) * tl + longint'(k_len_r) * tr;
    spd = (sum + 64'sd65536) >>> 17;
    travelled = travelled + spd[47:0];
    heading_sincos(head, s, c);
    dxp = (spd * s + (64'sd1 <<< 29)) >>> 30;
    dyp = (spd * c + (64'sd1 <<< 29)) >>> 30;
    at_x = at_x - dxp[31:0];
    at_y = at_y + dyp[31:0];
    range_bearing(longint'(signed'(it.ty)) - longint'(signed'(at_y)),
                  longint'(signed'(it.tx)) - longint'(signed'(at_x)), mag, ang);
    f.px = at_x; f.py = at_y; f.hd = head; f.sp = spd[31:0];
    f.rng = mag; f.brg = ang;
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued items, idling at random between them.
  always @(posedge clk) begin
    logic took;
    logic nv;
    odo_fix_t f;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_ticks_left  <= '0;
      in_ticks_right <= '0;
      in_target_x    <= '0;
      in_target_y    <= '0;
      in_restart     <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        advance_odometry(driven_item, f);
        expected_fixes.push_back(f);
      end
      nv = in_valid && !took;
      if (!nv && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        driven_item = pending_items.pop_front();
        in_ticks_left  <= driven_item.tl;
        in_ticks_right <= driven_item.tr;
        in_target_x    <= driven_item.tx;
        in_target_y    <= driven_item.ty;
        in_restart     <= driven_item.rs;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // Monitor: checks each result item against the oldest prediction.
  always @(posedge clk) begin
    odo_fix_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fixes.size() == 0) begin
          $display("unexpected result item at %0t", $time);
          errors++;
        end else begin
          w = expected_fixes.pop_front();
          if (out_pos_x !== w.px) report("pos_x", out_pos_x, w.px);
          if (out_pos_y !== w.py) report("pos_y", out_pos_y, w.py);
          if (out_heading !== w.hd) report("heading", 32'(out_heading), 32'(w.hd));
          if (out_speed !== w.sp) report("speed", out_speed, w.sp);
          if (out_target_distance !== w.rng)
            report("target_distance", out_target_distance, w.rng);
          if (out_target_bearing !== w.brg)
            report("target_bearing", 32'(out_target_bearing), 32'(w.brg));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_ANGLE_L:  k_ang_l = val[23:0];
      REG_ANGLE_R:  k_ang_r = val[23:0];
      REG_LENGTH_L: k_len_l = val[23:0];
      REG_LENGTH_R: k_len_r = val[23:0];
      REG_START_X:  home_x = val;
      REG_START_Y:  home_y = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] al, input logic [31:0] ar, input logic [31:0] ll,
                           input logic [31:0] lr, input logic [31:0] sx, input logic [31:0] sy);
    write_reg(REG_ANGLE_L, al);
    write_reg(REG_ANGLE_R, ar);
    write_reg(REG_LENGTH_L, ll);
    write_reg(REG_LENGTH_R, lr);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
  endtask

  task automatic queue_item(input logic [15:0] tl, input logic [15:0] tr,
                            input logic [31:0] tx, input logic [31:0] ty, input logic rs);
    odo_item_t it;
    it = '{tl: tl, tr: tr, tx: tx, ty: ty, rs: rs};
    pending_items.push_back(it);
  endtask

  task automatic drain;
    do @(posedge clk);
    while (!(pending_items.size() == 0 && !in_valid && expected_fixes.size() == 0));
    repeat (4) @(posedge clk);
  endtask

  // Mostly modest wheel motion; now and then full-range ticks and restarts.
  task automatic queue_random(input int n);
    logic [15:0] tl, tr;
    logic [31:0] tx, ty;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 2) begin
        tl = 16'($urandom); tr = 16'($urandom);
      end else begin
        tl = 16'($signed($urandom_range(400)) - 200);
        tr = 16'($signed($urandom_range(400)) - 200);
      end
      if ($urandom_range(3) == 0) begin
        tx = at_x + 32'($signed($urandom_range(2000)) - 1000);
        ty = at_y + 32'($signed($urandom_range(2000)) - 1000);
      end else begin
        tx = $urandom; ty = $urandom;
      end
      queue_item(tl, tr, tx, ty, $urandom_range(19) == 0);
    end
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    k_ang_l = '0; k_ang_r = '0; k_len_l = '0; k_len_r = '0;
    home_x = '0; home_y = '0; at_x = '0; at_y = '0; head = '0; travelled = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: nothing moves, only the target answer changes.
    queue_item(16'h7FFF, 16'h8000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    queue_item(16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b0);
    drain();

    write_all(32'h00A000, 32'h009000, 32'h012000, 32'h011000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    // Restart at the corner with zero ticks: range to the far corner saturates.
    queue_item(16'h0000, 16'h0000, 32'h80000000, 32'h80000000, 1'b1);
    // Restart with the target on the start point.
    queue_item(16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    queue_item(16'h7FFF, 16'h7FFF, 32'h00000000, 32'h00000000, 1'b0);
    queue_item(16'h8000, 16'h8000, 32'hFFFFFFFF, 32'h00000001, 1'b0);
    queue_item(16'h7FFF, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    queue_item(16'h8000, 16'h7FFF, 32'h12345678, 32'h87654321, 1'b0);
    queue_item(16'h0064, 16'h0032, 32'h00001000, 32'hFFFFF000, 1'b0);
    queue_item(16'hFF9C, 16'h0064, 32'hFFFF0000, 32'h00010000, 1'b0);
    queue_item(16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b1);
    queue_item(16'h0001, 16'hFFFF, 32'h80000000, 32'h80000000, 1'b0);
    drain();

    write_all(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'h80000000, 32'h80000000);
    queue_item(16'h0000, 16'h0000, 32'h80000000, 32'h80000000, 1'b1);
    queue_item(16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    queue_item(16'h8000, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    queue_item(16'h7FFF, 16'h8000, 32'h00000000, 32'h00000000, 1'b0);
    queue_item(16'h8000, 16'h7FFF, 32'h55555555, 32'hAAAAAAAA, 1'b0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      if (ph == 4)
        write_all(32'h0, 32'h0, 32'hFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000);
      else
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random(250);
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
